### src/srm_pkg.sv
// shared types, constants and the star-closure function of the regex matcher
package srm_pkg;

  localparam int MAX_ELEMENTS = 32;
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int SET_W        = MAX_ELEMENTS + 1;
  localparam int Q_DEPTH      = 2;
  localparam int QPTR_W       = $clog2(Q_DEPTH);
  localparam int QCNT_W       = $clog2(Q_DEPTH + 1);

  // input opcodes
  localparam logic [1:0] OP_CLEAR   = 2'd0;
  localparam logic [1:0] OP_PATTERN = 2'd1;
  localparam logic [1:0] OP_TEXT    = 2'd2;
  localparam logic [1:0] OP_END     = 2'd3;

  // pattern metacharacters
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_DOT    = 8'h2E;

  // classified command from the front to the engine
  typedef struct packed {
    logic       clear;
    logic       pattern;
    logic       text;
    logic       eot;
    logic [7:0] data;
  } srm_cmd_t;

  typedef logic [SET_W-1:0] srm_set_t;

  // spread active bits through runs of starred elements with one carry add
  function automatic srm_set_t srm_close(input srm_set_t set, input srm_set_t smask);
    srm_set_t sum;
    sum = (set & smask) + smask;
    return set | (sum ^ smask);
  endfunction

endpackage

### src/srm_front.sv
// front part: classifies incoming beats and queues them for the engine
module srm_front
  import srm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // in_byte
  input  logic [1:0] in_tuser,   // opcode
  output logic       cmd_valid,
  input  logic       cmd_ready,
  output srm_cmd_t   cmd
);

  srm_cmd_t          q_r [Q_DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  srm_cmd_t          dec;
  logic              push, pop;

  // decode the opcode into one-hot command kinds
  always_comb begin
    dec = '0;
    dec.data = in_tdata;
    case (in_tuser)
      OP_CLEAR:   dec.clear   = 1'b1;
      OP_PATTERN: dec.pattern = 1'b1;
      OP_TEXT:    dec.text    = 1'b1;
      OP_END:     dec.eot     = 1'b1;
      default:    dec.clear   = 1'b1;
    endcase
  end

  assign in_tready = (cnt_r != QCNT_W'(Q_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = cmd_valid && cmd_ready;

  // queue pointers
  always_comb begin
    wr_nxt  = push ? wr_r + 1'b1 : wr_r;
    rd_nxt  = pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= dec;
    end
  end

endmodule

### src/srm_engine.sv
// back part: pattern compiler, element store, nfa active set and result register
module srm_engine
  import srm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cmd_valid,
  output logic     cmd_ready,
  input  srm_cmd_t cmd,
  output logic     out_tvalid,
  input  logic     out_tready,
  output logic     res_matched,
  output logic     res_overflow
);

  logic [7:0]       el_char_r [MAX_ELEMENTS];
  logic [MAX_ELEMENTS-1:0] el_star_r, el_any_r;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             anchor_start_r, anchor_start_nxt;
  logic             anchor_end_r, anchor_end_nxt;
  logic [7:0]       held_r, held_nxt;
  logic             held_valid_r, held_valid_nxt;
  logic [1:0]       caret_r, caret_nxt;
  srm_set_t         active_r, active_nxt;
  logic             started_r, started_nxt;
  logic             sticky_r, sticky_nxt;
  logic             ovf_r, ovf_nxt;
  logic             out_valid_r, matched_r, res_ovf_r;

  logic             take, out_free, emit, hit;
  logic             add_en, add_star, add_ok;
  logic [7:0]       add_ch;
  logic [CNT_W-1:0] cnt_eff;
  logic [MAX_ELEMENTS-1:0] star_eff, any_eff, vmask, hitv, adv;
  logic [7:0]       char_eff [MAX_ELEMENTS];
  srm_set_t         smask, init_set, cur_set, step_set, acc_oh;
  logic             cur_sticky;

  assign out_free  = !out_valid_r || out_tready;
  assign cmd_ready = !cmd.eot || out_free;
  assign take      = cmd_valid && cmd_ready;

  // pattern compile, text start and bookkeeping
  always_comb begin
    count_nxt        = count_r;
    anchor_start_nxt = anchor_start_r;
    anchor_end_nxt   = anchor_end_r;
    held_nxt         = held_r;
    held_valid_nxt   = held_valid_r;
    caret_nxt        = caret_r;
    started_nxt      = started_r;
    sticky_nxt       = sticky_r;
    active_nxt       = active_r;
    ovf_nxt          = ovf_r;
    add_en           = 1'b0;
    add_ch           = held_r;
    add_star         = 1'b0;
    if (cmd.pattern) begin
      anchor_end_nxt = 1'b0;
      if (started_r) begin
        active_nxt  = '0;
        started_nxt = 1'b0;
        sticky_nxt  = 1'b0;
      end
      if (cmd.data == CH_CARET && caret_r < 2'd2 && count_r == '0 && !held_valid_r) begin
        caret_nxt        = caret_r + 2'd1;
        anchor_start_nxt = 1'b1;
      end else if (cmd.data == CH_STAR && held_valid_r) begin
        add_en         = 1'b1;
        add_star       = 1'b1;
        held_valid_nxt = 1'b0;
      end else begin
        add_en         = held_valid_r;
        held_nxt       = cmd.data;
        held_valid_nxt = 1'b1;
      end
    end else if ((cmd.text || cmd.eot) && !started_r && held_valid_r) begin
      if (held_r == CH_DOLLAR) begin
        anchor_end_nxt = 1'b1;
      end else begin
        add_en         = 1'b1;
        held_valid_nxt = 1'b0;
      end
    end
    add_ok = add_en && (count_r < CNT_W'(MAX_ELEMENTS));
    if (add_ok) begin
      count_nxt = count_r + 1'b1;
    end
    if (add_en && !add_ok) begin
      ovf_nxt = 1'b1;
    end
  end

  assign cnt_eff = count_nxt;

  // per-lane view of the store with this beat's element folded in
  always_comb begin
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      if (add_ok && count_r[IDX_W-1:0] == IDX_W'(i)) begin
        star_eff[i] = add_star;
        any_eff[i]  = (add_ch == CH_DOT);
        char_eff[i] = add_ch;
      end else begin
        star_eff[i] = el_star_r[i];
        any_eff[i]  = el_any_r[i];
        char_eff[i] = el_char_r[i];
      end
      vmask[i] = (CNT_W'(i) < cnt_eff);
      hitv[i]  = vmask[i] && (any_eff[i] || char_eff[i] == cmd.data);
    end
  end

  // nfa set update
  always_comb begin
    smask      = {1'b0, star_eff & vmask};
    acc_oh     = srm_set_t'(1) << cnt_eff;
    init_set   = srm_close(srm_set_t'(1), smask);
    cur_set    = started_r ? active_r : init_set;
    cur_sticky = started_r ? sticky_r : |(init_set & acc_oh);
    adv        = cur_set[MAX_ELEMENTS-1:0] & hitv;
    step_set   = {adv & ~star_eff, 1'b0} | {1'b0, adv & star_eff}
               | srm_set_t'(!anchor_start_r);
    step_set   = srm_close(step_set, smask);
    hit        = (anchor_end_nxt ? |(cur_set & acc_oh) : cur_sticky) && !ovf_nxt;
    emit       = take && cmd.eot;
  end

  // control and set registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r        <= '0;
      anchor_start_r <= 1'b0;
      anchor_end_r   <= 1'b0;
      held_r         <= '0;
      held_valid_r   <= 1'b0;
      caret_r        <= '0;
      active_r       <= '0;
      started_r      <= 1'b0;
      sticky_r       <= 1'b0;
      ovf_r          <= 1'b0;
    end else if (take) begin
      if (cmd.clear) begin
        count_r        <= '0;
        anchor_start_r <= 1'b0;
        anchor_end_r   <= 1'b0;
        held_r         <= '0;
        held_valid_r   <= 1'b0;
        caret_r        <= '0;
        active_r       <= '0;
        started_r      <= 1'b0;
        sticky_r       <= 1'b0;
        ovf_r          <= 1'b0;
      end else begin
        count_r        <= count_nxt;
        anchor_start_r <= anchor_start_nxt;
        anchor_end_r   <= anchor_end_nxt;
        held_r         <= held_nxt;
        held_valid_r   <= held_valid_nxt;
        caret_r        <= caret_nxt;
        ovf_r          <= ovf_nxt;
        if (cmd.text) begin
          active_r  <= step_set;
          started_r <= 1'b1;
          sticky_r  <= cur_sticky || |(step_set & acc_oh);
        end else if (cmd.eot) begin
          active_r  <= '0;
          started_r <= 1'b0;
          sticky_r  <= 1'b0;
        end else begin
          active_r  <= active_nxt;
          started_r <= started_nxt;
          sticky_r  <= sticky_nxt;
        end
      end
    end
  end

  // element store, at most one lane written per beat
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_ELEMENTS; i++) begin
      if (take && !cmd.clear && add_ok && count_r[IDX_W-1:0] == IDX_W'(i)) begin
        el_char_r[i] <= add_ch;
        el_star_r[i] <= add_star;
        el_any_r[i]  <= (add_ch == CH_DOT);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      matched_r <= hit;
      res_ovf_r <= ovf_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign res_matched  = matched_r;
  assign res_overflow = res_ovf_r;

  // checks
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_ELEMENTS)) else $error("element count past store");
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> count_r == CNT_W'(MAX_ELEMENTS)) else $error("overflow with room left");
  a_idle_set: assert property (@(posedge clk) disable iff (!rst_n)
    !started_r |-> (active_r == '0 && !sticky_r)) else $error("set live without text");
  a_caret: assert property (@(posedge clk) disable iff (!rst_n)
    caret_r != 2'd3) else $error("too many carets");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free) else $error("result overwritten");

endmodule

### src/simple_regex_matcher_core.sv
// top level of the streaming regex matcher
// Send opcode 0 to clear, pattern bytes with opcode 1, then text bytes with opcode 2 and
// opcode 3 to close a text; opcode 3 returns one beat with matched and the overflow flag.
// The nfa engine takes one beat per cycle unless an end beat waits on a held result, so beats
// can follow back to back; star-closure carry adds over the 33-bit active set bound that rate. A
// two-beat queue sits in front of the engine and a result register behind it, so input is
// only held off while the queue is full, which happens when a result waits on out_tready.
module simple_regex_matcher_core
  import srm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // in_byte[7:0]
  input  logic [1:0] in_tuser,   // opcode[1:0]
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // matched[0], zero fill [7:1]
  output logic       out_tuser   // pattern_overflow
);

  srm_cmd_t cmd;
  logic     cmd_valid, cmd_ready, matched;

  srm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  srm_engine u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .res_matched  (matched),
    .res_overflow (out_tuser)
  );

  assign out_tdata = {7'd0, matched};

endmodule
